/* hw/rtl/ofla_pkg.sv */
// Shared types and constants for the object name free list allocator.
// No dependencies; every other file in this block imports this package.
package ofla_pkg;

  // Default number of entries in the link store.
  localparam int DEFAULT_NUM_NAMES = 64;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Command codes on in_cmd.
  localparam logic [1:0] CMD_GEN = 2'd0;
  localparam logic [1:0] CMD_REL = 2'd1;
  localparam logic [1:0] CMD_QRY = 2'd2;

  // Status codes on out_status.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NO_MEM    = 2'd2;
  localparam logic [1:0] ST_NOT_BOUND = 2'd3;

  // Operation class decided by the front part.
  typedef enum logic [1:0] {
    OP_GEN,
    OP_REL,
    OP_QRY,
    OP_BAD
  } op_t;

  // One queued beat from the front to the back.
  typedef struct packed {
    op_t        op;
    logic [5:0] want;
    logic [5:0] name;
  } item_t;

  // One result beat from the back to the output ports.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [5:0] given_name;
    logic       is_bound;
    logic       last;
  } result_t;

endpackage

/* hw/rtl/ofla_front.sv */
// Front part: input handshake and command classification.
// Depends on ofla_pkg for command codes and the queued item type.
module ofla_front import ofla_pkg::*; (
  input  logic              start,
  input  logic              queue_full,
  input  logic              clearing,
  input  logic [1:0]        in_cmd,
  input  logic signed [6:0] in_count,
  input  logic [5:0]        in_name,
  output logic              busy,
  output logic              push,
  output item_t             push_item
);

  op_t  op;
  logic accept;
  logic drop;

  // A beat is taken whenever the queue has room and the link store is ready.
  assign busy   = queue_full | clearing;
  assign accept = start & ~busy;

  // Classify the command; a generate with a negative count or an unused code is invalid.
  always_comb begin
    unique case (in_cmd)
      CMD_GEN: op = in_count[6] ? OP_BAD : OP_GEN;
      CMD_REL: op = OP_REL;
      CMD_QRY: op = OP_QRY;
      default: op = OP_BAD;
    endcase
  end

  // A generate of zero names produces nothing, so it never enters the queue.
  assign drop = (op == OP_GEN) && (in_count[5:0] == 6'd0);

  assign push           = accept & ~drop;
  assign push_item.op   = op;
  assign push_item.want = in_count[5:0];
  assign push_item.name = in_name;

endmodule

/* hw/rtl/ofla_queue.sv */
// Small FIFO that decouples command classification from execution.
// Depends on ofla_pkg for the item type and the queue depth.
module ofla_queue import ofla_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  valid,
  output item_t head_item,
  output logic  full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign valid     = (fill_r != '0);
  assign full      = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign head_item = slots_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & valid;

  // Pointer wrap and fill tracking.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/ofla_back.sv */
// Back part: owns the link store, the list head and the free count, and
// executes queued commands. Depends on ofla_pkg for item and result types.
module ofla_back import ofla_pkg::*; #(
  parameter int NUM_NAMES = DEFAULT_NUM_NAMES
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    clearing,
  output result_t result
);

  localparam int IDX_W  = (NUM_NAMES > 2) ? $clog2(NUM_NAMES) : 1;
  localparam int LINK_W = $clog2(NUM_NAMES + 2);

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam link_t LINK_NIL   = LINK_W'(NUM_NAMES);
  localparam link_t LINK_BOUND = LINK_W'(NUM_NAMES + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP_RD,
    S_POP_WR,
    S_REV_RD,
    S_REV_WR,
    S_REL_CHK,
    S_QRY_CHK
  } state_t;

  // Link store; entry 0 is unused since the head lives in head_r.
  link_t   mem [NUM_NAMES];
  link_t   rdata_r;
  logic    rd_en;
  idx_t    rd_addr;
  logic    wr_en;
  idx_t    wr_addr;
  link_t   wr_data;

  state_t  state_r, state_nxt;
  idx_t    clr_r, clr_nxt;
  link_t   head_r, head_nxt;
  idx_t    free_r, free_nxt;
  logic [5:0] left_r, left_nxt;
  link_t   cur_r, cur_nxt;
  link_t   prev_r, prev_nxt;
  idx_t    name_r, name_nxt;
  result_t res_r, res_nxt;

  logic    name_ok;
  logic    short;

  assign clearing = (state_r == S_CLEAR);
  assign result   = res_r;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  // Name 0 and names past the store are never bound.
  assign name_ok = (q_item.name != 6'd0) && (32'(q_item.name) < NUM_NAMES);
  assign short   = 32'(q_item.want) > 32'(free_r);

  // Command sequencer.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    head_nxt  = head_r;
    free_nxt  = free_r;
    left_nxt  = left_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    name_nxt  = name_r;
    res_nxt   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;

    unique case (state_r)
      // Write the reset links, one entry per cycle.
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = LINK_W'(clr_r) + LINK_W'(1);
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(NUM_NAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a queued beat and decide how to carry it out.
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_GEN: begin
              if (short) begin
                if (free_r == '0) begin
                  res_nxt = '{valid: 1'b1, status: ST_NO_MEM, given_name: 6'd0,
                              is_bound: 1'b0, last: 1'b1};
                end else begin
                  // Too few names: reverse the whole free list in place.
                  cur_nxt   = head_r;
                  prev_nxt  = LINK_NIL;
                  state_nxt = S_REV_RD;
                end
              end else begin
                free_nxt  = free_r - IDX_W'(q_item.want);
                left_nxt  = q_item.want;
                state_nxt = S_POP_RD;
              end
            end
            OP_REL: begin
              if (name_ok) begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(q_item.name);
                name_nxt  = IDX_W'(q_item.name);
                state_nxt = S_REL_CHK;
              end else begin
                res_nxt = '{valid: 1'b1, status: ST_NOT_BOUND, given_name: 6'd0,
                            is_bound: 1'b0, last: 1'b1};
              end
            end
            OP_QRY: begin
              if (name_ok) begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(q_item.name);
                state_nxt = S_QRY_CHK;
              end else begin
                res_nxt = '{valid: 1'b1, status: ST_OK, given_name: 6'd0,
                            is_bound: 1'b0, last: 1'b1};
              end
            end
            default: begin
              res_nxt = '{valid: 1'b1, status: ST_INVALID, given_name: 6'd0,
                          is_bound: 1'b0, last: 1'b1};
            end
          endcase
        end
      end

      // Fetch the successor of the head.
      S_POP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = head_r[IDX_W-1:0];
        state_nxt = S_POP_WR;
      end

      // Mark the head bound, advance the head and hand out the name.
      S_POP_WR: begin
        wr_en    = 1'b1;
        wr_addr  = head_r[IDX_W-1:0];
        wr_data  = LINK_BOUND;
        head_nxt = rdata_r;
        left_nxt = left_r - 6'd1;
        res_nxt  = '{valid: 1'b1, status: ST_OK, given_name: 6'(head_r),
                     is_bound: 1'b0, last: (left_r == 6'd1)};
        state_nxt = (left_r == 6'd1) ? S_IDLE : S_POP_RD;
      end

      // Fetch the link of the current node of the reversal walk.
      S_REV_RD: begin
        rd_en     = 1'b1;
        rd_addr   = cur_r[IDX_W-1:0];
        state_nxt = S_REV_WR;
      end

      // Point the current node back at the previous one.
      S_REV_WR: begin
        wr_en    = 1'b1;
        wr_addr  = cur_r[IDX_W-1:0];
        wr_data  = prev_r;
        prev_nxt = cur_r;
        if ((rdata_r >= LINK_NIL) || (rdata_r == '0)) begin
          head_nxt  = cur_r;
          res_nxt   = '{valid: 1'b1, status: ST_NO_MEM, given_name: 6'd0,
                        is_bound: 1'b0, last: 1'b1};
          state_nxt = S_IDLE;
        end else begin
          cur_nxt   = rdata_r;
          state_nxt = S_REV_RD;
        end
      end

      // Push a bound name back onto the head; report any other name as not bound.
      S_REL_CHK: begin
        if (rdata_r == LINK_BOUND) begin
          wr_en    = 1'b1;
          wr_addr  = name_r;
          wr_data  = head_r;
          head_nxt = LINK_W'(name_r);
          free_nxt = free_r + IDX_W'(1);
          res_nxt  = '{valid: 1'b1, status: ST_OK, given_name: 6'd0,
                       is_bound: 1'b0, last: 1'b1};
        end else begin
          res_nxt  = '{valid: 1'b1, status: ST_NOT_BOUND, given_name: 6'd0,
                       is_bound: 1'b0, last: 1'b1};
        end
        state_nxt = S_IDLE;
      end

      S_QRY_CHK: begin
        res_nxt   = '{valid: 1'b1, status: ST_OK, given_name: 6'd0,
                      is_bound: (rdata_r == LINK_BOUND), last: 1'b1};
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      head_r      <= LINK_W'(1);
      free_r      <= IDX_W'(NUM_NAMES - 1);
      res_r.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      res_r   <= res_nxt;
    end
  end

  // Walk registers carry payload only.
  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    name_r <= name_nxt;
  end

  // Single-port link store with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/object_name_free_list_allocator.sv */
// Top level of the object name free list allocator.
// Depends on ofla_pkg, ofla_front, ofla_queue and ofla_back.
//
// Hands out object names 1 to NUM_NAMES-1 from a linked free list. A beat is
// taken at a clock edge where start is high and busy is low. After reset the
// block runs a clearing pass over the link store and holds busy high
// meanwhile. Beats enter a two-entry queue, so busy also rises while that
// queue is full. Each result is shown for one cycle with out_valid high and
// must be taken then: the receiver cannot stall. A generate of n names hands
// them out one by one, since each pop is a dependent read of the single-port
// link store with registered read data. A generate that finds too few free
// names walks the whole free list before its out-of-memory result. A release
// or query of a name inside the store reads its link before it answers. A
// release or query of name 0 or of a name past the store is answered without
// a read, as is an invalid command, and a generate of zero names gives no
// result at all.
module object_name_free_list_allocator import ofla_pkg::*; #(
  parameter int NUM_NAMES = DEFAULT_NUM_NAMES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_cmd,
  input  logic signed [6:0] in_count,
  input  logic [5:0]        in_name,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [5:0]        out_given_name,
  output logic              out_is_bound,
  output logic              out_last
);

  logic    queue_full;
  logic    clearing;
  logic    push;
  item_t   push_item;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t result;

  // Accept and classify.
  ofla_front u_front (
    .start      (start),
    .queue_full (queue_full),
    .clearing   (clearing),
    .in_cmd     (in_cmd),
    .in_count   (in_count),
    .in_name    (in_name),
    .busy       (busy),
    .push       (push),
    .push_item  (push_item)
  );

  // Decoupling queue.
  ofla_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_item (q_item),
    .full      (queue_full)
  );

  // Execute against the link store.
  ofla_back #(
    .NUM_NAMES (NUM_NAMES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .clearing (clearing),
    .result   (result)
  );

  assign out_valid      = result.valid;
  assign out_status     = result.status;
  assign out_given_name = result.given_name;
  assign out_is_bound   = result.is_bound;
  assign out_last       = result.last;

endmodule

/* hw/rtl/ofla_checker.sv */
// Port-level checks for the object name free list allocator, bound to the top.
// Depends on ofla_pkg for the status codes.
module ofla_checker import ofla_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [1:0]        in_cmd,
  input logic signed [6:0] in_count,
  input logic [5:0]        in_name,
  input logic              out_valid,
  input logic [1:0]        out_status,
  input logic [5:0]        out_given_name,
  input logic              out_is_bound,
  input logic              out_last
);

  // Reset always starts the clearing pass, which holds busy.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy not raised after reset");

  // Only a successful generate spreads over several result beats.
  a_multi_is_gen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK && !out_is_bound)
    else $error("non-final beat is not a generate result");

  // Error results carry no name and no bound flag.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_given_name == 6'd0 && !out_is_bound && out_last)
    else $error("error beat carries payload");

  // A bound query answer is a single clean beat.
  a_query_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_bound |-> out_given_name == 6'd0 && out_last)
    else $error("bound answer mixed with a name");

  // Each pop needs a link read, so name beats never come back to back.
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> !out_valid)
    else $error("generate beats too close together");

endmodule

bind object_name_free_list_allocator ofla_checker u_ofla_checker (.*);

/* tb/ofla_scoreboard.sv */
// Scoreboard for the object name free list allocator: predicts every result beat
// from the accepted command beats and compares the result ports field by field.
// Depends on ofla_pkg for the command and status codes.
`timescale 1ns / 1ps

module ofla_scoreboard import ofla_pkg::*; #(
  parameter int NUM_NAMES = DEFAULT_NUM_NAMES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_cmd,
  input  logic signed [6:0] in_count,
  input  logic [5:0]        in_name,
  input  logic              out_valid,
  input  logic [1:0]        out_status,
  input  logic [5:0]        out_given_name,
  input  logic              out_is_bound,
  input  logic              out_last,
  output int                fail_count,
  output int                pending,
  output int                checked_total
);

  localparam int LINK_W = $clog2(NUM_NAMES + 2);
  localparam logic [LINK_W-1:0] LINK_NIL   = LINK_W'(NUM_NAMES);
  localparam logic [LINK_W-1:0] LINK_TAKEN = LINK_W'(NUM_NAMES + 1);

  // One expected result beat.
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] given_name;
    logic       is_bound;
    logic       last;
  } alloc_beat_t;

  // Shadow copy of the link store; entry 0 is the head of the free list.
  logic [LINK_W-1:0] link_mem [NUM_NAMES];
  alloc_beat_t       expected_beats [$];
  int                mismatches;
  int                checked;

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_total = 0;
    mismatches    = 0;
    checked       = 0;
  end

  function automatic void expect_beat(input logic [1:0] st, input logic [5:0] nm,
                                      input logic bnd, input logic lst);
    alloc_beat_t b;
    b.status     = st;
    b.given_name = nm;
    b.is_bound   = bnd;
    b.last       = lst;
    expected_beats.push_back(b);
  endfunction

  function automatic logic name_is_bound(input logic [5:0] nm);
    if (nm == 0 || int'(nm) >= NUM_NAMES) return 1'b0;
    return link_mem[nm] == LINK_TAKEN;
  endfunction

  function automatic void push_free(input logic [5:0] nm);
    link_mem[nm] = link_mem[0];
    link_mem[0]  = LINK_W'(nm);
  endfunction

  // Apply one accepted command to the shadow store and queue its result beats.
  function automatic void predict_alloc(input logic [1:0] cmd,
                                        input logic signed [6:0] cnt,
                                        input logic [5:0] nm);
    logic [5:0]  popped [$];
    logic [LINK_W-1:0] head;
    int unsigned want;
    if (cmd == CMD_GEN) begin
      if (cnt < 0) begin
        expect_beat(ST_INVALID, '0, 1'b0, 1'b1);
        return;
      end
      want = int'(cnt);
      if (want == 0) return;
      // Pop from the head; a head outside the name range counts as an empty list.
      while (popped.size() < want) begin
        head = link_mem[0];
        if (head == 0 || int'(head) >= NUM_NAMES) break;
        link_mem[0]    = link_mem[head];
        link_mem[head] = LINK_TAKEN;
        popped.push_back(head[5:0]);
      end
      if (popped.size() < want) begin
        // Roll back in pop order, which leaves the free list reversed.
        foreach (popped[i]) push_free(popped[i]);
        expect_beat(ST_NO_MEM, '0, 1'b0, 1'b1);
      end else begin
        foreach (popped[i]) expect_beat(ST_OK, popped[i], 1'b0, i == want - 1);
      end
    end else if (cmd == CMD_REL) begin
      if (!name_is_bound(nm)) begin
        expect_beat(ST_NOT_BOUND, '0, 1'b0, 1'b1);
      end else begin
        push_free(nm);
        expect_beat(ST_OK, '0, 1'b0, 1'b1);
      end
    end else if (cmd == CMD_QRY) begin
      expect_beat(ST_OK, '0, name_is_bound(nm), 1'b1);
    end else begin
      expect_beat(ST_INVALID, '0, 1'b0, 1'b1);
    end
  endfunction

  // Predict on each accepted command beat, then check any result beat of this edge.
  always @(posedge clk) begin
    alloc_beat_t want_beat;
    if (!rst_n) begin
      for (int i = 0; i < NUM_NAMES; i++) link_mem[i] = LINK_W'(i + 1);
      link_mem[NUM_NAMES-1] = LINK_NIL;
      expected_beats.delete();
    end else begin
      if (start && !busy) predict_alloc(in_cmd, in_count, in_name);
      if (out_valid) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: status %0d, given_name %0d", out_status,
                 out_given_name);
          mismatches++;
        end else begin
          want_beat = expected_beats.pop_front();
          checked++;
          if (out_status !== want_beat.status) begin
            $error("out_status: expected %0d, got %0d", want_beat.status, out_status);
            mismatches++;
          end
          if (out_given_name !== want_beat.given_name) begin
            $error("out_given_name: expected %0d, got %0d", want_beat.given_name,
                   out_given_name);
            mismatches++;
          end
          if (out_is_bound !== want_beat.is_bound) begin
            $error("out_is_bound: expected %0d, got %0d", want_beat.is_bound,
                   out_is_bound);
            mismatches++;
          end
          if (out_last !== want_beat.last) begin
            $error("out_last: expected %0d, got %0d", want_beat.last, out_last);
            mismatches++;
          end
        end
      end
    end
    // Publish after the edge so readers in the same step see a stable value.
    fail_count    <= mismatches;
    pending       <= expected_beats.size();
    checked_total <= checked;
  end

endmodule

/* tb/tb_object_name_free_list_allocator.sv */
// Testbench top for the object name free list allocator: drives a directed
// sequence, then random bursts, and gives the verdict. Depends on ofla_pkg,
// the block and ofla_scoreboard, which does all prediction and checking.
`timescale 1ns / 1ps

module tb_object_name_free_list_allocator import ofla_pkg::*;;

  localparam int NUM_NAMES = DEFAULT_NUM_NAMES;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 156;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 160;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_cmd = '0;
  logic signed [6:0] in_count = '0;
  logic [5:0]        in_name = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [5:0]        out_given_name;
  logic              out_is_bound;
  logic              out_last;
  int                fail_count;
  int                pending;
  int                checked_total;

  // Names seen handed out and not yet released; steers releases to bound names.
  bit bound_map [NUM_NAMES];
  int n_gen = 0;
  int n_rel = 0;
  int n_qry = 0;
  int n_bad = 0;
  int quiet_cycles = 0;

  object_name_free_list_allocator #(.NUM_NAMES(NUM_NAMES)) i_dut (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_count, .in_name,
    .out_valid, .out_status, .out_given_name, .out_is_bound, .out_last
  );

  ofla_scoreboard #(.NUM_NAMES(NUM_NAMES)) i_scoreboard (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_count, .in_name,
    .out_valid, .out_status, .out_given_name, .out_is_bound, .out_last,
    .fail_count, .pending, .checked_total
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Track names as their generate beats come out.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_status == ST_OK && out_given_name != 0)
      bound_map[out_given_name] = 1'b1;
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout after %0d quiet cycles, %0d results still pending.",
               QUIET_LIMIT, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command beat and hold it until the block takes it.
  task automatic send_cmd(input logic [1:0] cmd, input logic signed [6:0] cnt,
                          input logic [5:0] nm);
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_count <= cnt;
    in_name  <= nm;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (cmd)
      CMD_GEN: n_gen++;
      CMD_REL: begin
        n_rel++;
        bound_map[nm] = 1'b0;
      end
      CMD_QRY: n_qry++;
      default: n_bad++;
    endcase
  endtask

  task automatic idle(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every predicted result beat has come out.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [5:0] pick_bound_name();
    logic [5:0] held [$];
    for (int i = 1; i < NUM_NAMES; i++) if (bound_map[i]) held.push_back(6'(i));
    if (held.size() == 0) return 6'($urandom_range(0, NUM_NAMES - 1));
    return held[$urandom_range(0, held.size() - 1)];
  endfunction

  // One random command beat; unused fields carry random values too.
  task automatic send_random();
    int roll;
    int sz;
    logic signed [6:0] cnt;
    logic [5:0] nm;
    roll = $urandom_range(0, 99);
    cnt  = 7'($urandom);
    nm   = 6'($urandom);
    if (roll < 40) begin
      sz = $urandom_range(0, 99);
      if (sz < 75) cnt = 7'($urandom_range(1, 6));
      else if (sz < 85) cnt = 7'($urandom_range(7, 63));
      else if (sz < 95) cnt = 7'(-int'($urandom_range(1, 64)));
      else cnt = '0;
      send_cmd(CMD_GEN, cnt, nm);
    end else if (roll < 75) begin
      if ($urandom_range(0, 4) != 0) nm = pick_bound_name();
      send_cmd(CMD_REL, cnt, nm);
    end else if (roll < 93) begin
      if ($urandom_range(0, 1) != 0) nm = pick_bound_name();
      send_cmd(CMD_QRY, cnt, nm);
    end else begin
      send_cmd(CMD_UNUSED, cnt, nm);
    end
  endtask

  initial begin
    int burst_left;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: list walk, rollback, exhaustion and every bad case.
    send_cmd(CMD_GEN, 7'sd1, 6'd0);
    send_cmd(CMD_QRY, 7'sd0, 6'd1);
    send_cmd(CMD_QRY, -7'sd64, 6'd0);
    send_cmd(CMD_QRY, 7'sd63, 6'd63);
    idle(3);
    send_cmd(CMD_REL, 7'sd0, 6'd0);
    send_cmd(CMD_REL, 7'sd5, 6'd2);
    send_cmd(CMD_GEN, 7'sd0, 6'd63);
    send_cmd(CMD_GEN, -7'sd64, 6'd0);
    send_cmd(CMD_GEN, -7'sd1, 6'd42);
    send_cmd(CMD_UNUSED, 7'sd63, 6'd63);
    // Asks for more than is free, so the list comes back reversed.
    send_cmd(CMD_GEN, 7'sd63, 6'd21);
    send_cmd(CMD_GEN, 7'sd3, 6'd0);
    idle(7);
    send_cmd(CMD_REL, 7'sd0, 6'd1);
    // Takes every remaining name, then finds the list empty.
    send_cmd(CMD_GEN, 7'sd60, 6'd0);
    send_cmd(CMD_GEN, 7'sd1, 6'd0);
    drain();
    send_cmd(CMD_REL, 7'sd0, 6'd63);
    send_cmd(CMD_REL, 7'sd0, 6'd63);
    send_cmd(CMD_QRY, 7'sd0, 6'd63);
    send_cmd(CMD_QRY, 7'sd0, 6'd62);
    send_cmd(CMD_GEN, 7'sd1, 6'd0);
    send_cmd(CMD_REL, 7'sd0, 6'd5);
    send_cmd(CMD_REL, 7'sd0, 6'd40);
    send_cmd(CMD_REL, 7'sd0, 6'd17);
    send_cmd(CMD_GEN, 7'sd63, 6'd0);
    drain();

    // Random part in bursts, with one full drain halfway through.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 2) drain();
      if (burst_left == 0) begin
        idle($urandom_range(1, 15));
        burst_left = $urandom_range(1, 12);
      end
      send_random();
      burst_left--;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d commands: %0d generates, %0d releases, %0d queries, %0d unused codes.",
             n_gen + n_rel + n_qry + n_bad, n_gen, n_rel, n_qry, n_bad);
    $display("Checked %0d result beats against the prediction.", checked_total);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ofla_pkg.sv
hw/rtl/ofla_front.sv
hw/rtl/ofla_queue.sv
hw/rtl/ofla_back.sv
hw/rtl/object_name_free_list_allocator.sv
hw/rtl/ofla_checker.sv
tb/ofla_scoreboard.sv
tb/tb_object_name_free_list_allocator.sv
